@@ sv/qpe_pkg.sv @@
// ---------------------------------------------------------------------------
// qpe_pkg - shared types and constants for the quoted-printable encoder
// Character codes, result buffer sizing, encoder state layout, hex table.
// ---------------------------------------------------------------------------
package qpe_pkg;

  localparam int unsigned MaxOut   = 6;                 // results per item
  localparam int unsigned CntW     = $clog2(MaxOut + 1);
  localparam int unsigned LineW    = 7;
  localparam int unsigned ThrW     = 7;

  localparam logic [ThrW-1:0] ThrReset = 7'd74;

  localparam logic [7:0] ChEq  = 8'h3D;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChSp  = 8'h20;
  localparam logic [7:0] ChHt  = 8'h09;
  localparam logic [7:0] ChDot = 8'h2E;
  localparam logic [7:0] ChDel = 8'h7F;

  localparam logic CmdData = 1'b0;
  localparam logic CmdEos  = 1'b1;

  typedef logic [7:0] byte_t;
  typedef byte_t [MaxOut-1:0] obuf_t;

  typedef struct packed {
    logic [LineW-1:0] line_count;
    byte_t            prev_char;
    logic             ended_in_space;
  } qpe_state_t;

  // Upper-case hex digit for a nibble.
  function automatic byte_t hex_digit(input logic [3:0] nib);
    byte_t d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'h0, nib};
    end else begin
      d = 8'h37 + {4'h0, nib};
    end
    return d;
  endfunction

endpackage

@@ sv/quoted_printable_encoder.sv @@
// ---------------------------------------------------------------------------
// quoted_printable_encoder - streaming quoted-printable encoder
// Encodes one byte per input transfer into zero to six output characters,
// with soft line breaks once the line passes the programmed threshold.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  -----------------------------------
//  in       input      in_valid/in_ready    in_cmd, in_data_byte
//  out      output     out_valid/out_ready  out_out_byte, out_last
//  cfg      input      cfg_valid/cfg_ready  cfg_soft_break_threshold
//
//  An item holds out for one transfer per character it produces (1..6), and
//  for none if it produces none; the single-character output port sets that.
//  Each item goes through the input register and then the result buffer.
//  Synchronous active-low reset empties both stages, clears the line state
//  and sets the threshold to 74. A stall on out holds the current character;
//  in keeps accepting into the input register until that register is full.
//
module quoted_printable_encoder
  import qpe_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_cmd,
  input  logic [7:0]      in_data_byte,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_out_byte,
  output logic            out_last,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [ThrW-1:0] cfg_soft_break_threshold
);

  // input register
  logic            s1_valid_r, s1_valid_nxt;
  logic            s1_cmd_r;
  byte_t           s1_byte_r;

  // line state and threshold
  qpe_state_t      state_r, state_nxt;
  logic [ThrW-1:0] thr_r, thr_nxt;

  // encode results
  obuf_t           enc_bytes;
  logic [CntW-1:0] enc_count;
  qpe_state_t      enc_state;

  logic            in_xfer;
  logic            load;
  logic            drain;
  logic            busy;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;

  // Advance the input register into the result buffer once the buffer is
  // empty or gives up its final character this cycle.
  assign load     = s1_valid_r && (!busy || drain);
  assign in_ready = !s1_valid_r || load;

  qpe_core u_core (
    .cmd       (s1_cmd_r),
    .data_byte (s1_byte_r),
    .state     (state_r),
    .threshold (thr_r),
    .bytes     (enc_bytes),
    .count     (enc_count),
    .state_nxt (enc_state)
  );

  qpe_obuf u_obuf (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (load),
    .load_bytes   (enc_bytes),
    .load_count   (enc_count),
    .drain        (drain),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_byte (out_out_byte),
    .out_last     (out_last)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (load) begin
      s1_valid_nxt = 1'b0;
    end
    // commit the line state as the item leaves the input register
    state_nxt = load ? enc_state : state_r;
    thr_nxt   = (cfg_valid && cfg_ready) ? cfg_soft_break_threshold : thr_r;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r  <= in_cmd;
      s1_byte_r <= in_data_byte;
    end
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      state_r    <= '0;
      thr_r      <= ThrReset;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      state_r    <= state_nxt;
      thr_r      <= thr_nxt;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with empty input register");

  a_eos_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (load && s1_cmd_r == CmdEos) |=> (state_r == '0))
    else $error("end of stream left line state behind");

  a_state_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(state_r))
    else $error("line state moved without an item");

endmodule

@@ sv/qpe_core.sv @@
// ---------------------------------------------------------------------------
// qpe_core - per-byte encode logic
// Maps one input item and the current line state to up to six output
// characters and the next line state.
// ---------------------------------------------------------------------------
module qpe_core
  import qpe_pkg::*;
(
  input  logic             cmd,
  input  byte_t            data_byte,
  input  qpe_state_t       state,
  input  logic [ThrW-1:0]  threshold,
  output obuf_t            bytes,
  output logic [CntW-1:0]  count,
  output qpe_state_t       state_nxt
);

  obuf_t            base;
  logic [CntW-1:0]  n0;
  logic [LineW:0]   len;
  logic             brk;

  always_comb begin
    base      = '0;
    n0        = '0;
    len       = {1'b0, state.line_count};
    state_nxt = state;

    if (cmd == CmdEos) begin
      if (state.line_count != '0) begin
        base[0] = ChCr;
        base[1] = ChLf;
        n0      = CntW'(2);
      end
      state_nxt = '0;
    end else if (data_byte > ChSp && data_byte < ChDel && data_byte != ChEq) begin
      base[0]                  = data_byte;
      n0                       = CntW'(1);
      len                      = len + (LineW+1)'(1);
      state_nxt.ended_in_space = 1'b0;
      state_nxt.prev_char      = data_byte;
    end else if (data_byte == ChSp || data_byte == ChHt) begin
      base[0]                  = data_byte;
      n0                       = CntW'(1);
      len                      = len + (LineW+1)'(1);
      state_nxt.ended_in_space = 1'b1;
      state_nxt.prev_char      = data_byte;
    end else if (data_byte == ChLf && state.prev_char == ChCr) begin
      // second half of a CR LF pair: already closed
      state_nxt.prev_char = '0;
    end else if (data_byte == ChCr || data_byte == ChLf) begin
      if (state.ended_in_space ||
          (state.prev_char == ChDot && state.line_count == LineW'(1))) begin
        base[0] = ChEq;
        base[1] = ChCr;
        base[2] = ChLf;
        base[3] = ChCr;
        base[4] = ChLf;
        n0      = CntW'(5);
      end else begin
        base[0] = ChCr;
        base[1] = ChLf;
        n0      = CntW'(2);
      end
      state_nxt.ended_in_space = 1'b0;
      state_nxt.prev_char      = data_byte;
      len                      = '0;
    end else begin
      base[0]                  = ChEq;
      base[1]                  = hex_digit(data_byte[7:4]);
      base[2]                  = hex_digit(data_byte[3:0]);
      n0                       = CntW'(3);
      len                      = len + (LineW+1)'(3);
      state_nxt.ended_in_space = 1'b0;
      state_nxt.prev_char      = data_byte;
    end

    brk   = (cmd == CmdData) && (len > {1'b0, threshold});
    bytes = base;
    count = n0;

    // append the soft break right after the base characters
    if (brk) begin
      for (int i = 0; i < MaxOut; i++) begin
        if (CntW'(i) == n0) begin
          bytes[i] = ChEq;
        end else if ((CntW+1)'(i) == {1'b0, n0} + (CntW+1)'(1)) begin
          bytes[i] = ChCr;
        end else if ((CntW+1)'(i) == {1'b0, n0} + (CntW+1)'(2)) begin
          bytes[i] = ChLf;
        end
      end
      count               = n0 + CntW'(3);
      len                 = '0;
      state_nxt.prev_char = '0;
    end

    if (cmd == CmdData) begin
      state_nxt.line_count = len[LineW-1:0];
    end
  end

endmodule

@@ sv/qpe_obuf.sv @@
// ---------------------------------------------------------------------------
// qpe_obuf - result shift buffer
// Holds the characters of one item and shifts them out one per transfer.
// ---------------------------------------------------------------------------
module qpe_obuf
  import qpe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  obuf_t            load_bytes,
  input  logic [CntW-1:0]  load_count,
  output logic             drain,       // final character leaves this cycle
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output byte_t            out_out_byte,
  output logic             out_last
);

  obuf_t           buf_r, buf_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            xfer;

  assign out_valid    = (cnt_r != '0);
  assign busy         = out_valid;
  assign out_out_byte = buf_r[0];
  assign out_last     = (cnt_r == CntW'(1));
  assign xfer         = out_valid && out_ready;
  assign drain        = xfer && out_last;

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (load) begin
      buf_nxt = load_bytes;
      cnt_nxt = load_count;
    end else if (xfer) begin
      buf_nxt = {8'h00, buf_r[MaxOut-1:1]};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxOut))
    else $error("result count out of range");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid || drain))
    else $error("load over a pending result");

  a_hold_unless_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(cnt_r) && $stable(out_out_byte))
    else $error("result changed while stalled");

endmodule
